// File: sv/pac_pkg.sv
// Shared types and constants for the packet airtime calculator.
// No dependencies.
`default_nettype none
package pac_pkg;

  localparam int LEN_W     = 8;
  localparam int SF_W      = 4;
  localparam int BW_W      = 9;
  localparam int CR_W      = 3;
  localparam int PRE_W     = 16;
  localparam int SYMS_W    = 10;
  localparam int QUARTER_W = 19;
  localparam int AIR_W     = 39;

  localparam int IN_DATA_W  = 16;
  localparam int OUT_DATA_W = 72;
  localparam int CFG_ADDR_W = 3;
  localparam int CFG_DATA_W = 16;

  // first divider: (num - 1) / 4 by the effective spreading factor
  localparam int D1_RW = SF_W;
  localparam int D1_QW = 10;
  localparam int D1_SW = 1 + SF_W + 1;

  // second divider: quarter * 250 * 2^sf by bandwidth
  localparam int D2_RW = BW_W;
  localparam int D2_QW = 42;
  localparam int D2_SW = SYMS_W + QUARTER_W + 1;

  localparam logic [BW_W-1:0]   BW_LRO_KHZ = 9'd125;
  localparam logic [SF_W-1:0]   SF_LRO_MIN = 4'd11;
  localparam logic [SYMS_W-1:0] SYMS_FIXED = 10'd8;
  localparam logic [SYMS_W-1:0] SYMS_MAX   = 10'd1023;

  typedef enum logic [CFG_ADDR_W-1:0] {
    REG_BANDWIDTH = 3'd0,
    REG_CODING    = 3'd1,
    REG_CRC       = 3'd2,
    REG_IMPLICIT  = 3'd3,
    REG_LRO       = 3'd4,
    REG_PREAMBLE  = 3'd5
  } cfg_reg_t;

endpackage
`default_nettype wire

// File: sv/packet_airtime_calculator_top.sv
// Packet airtime calculator: time on air of a chirp-spread-spectrum packet.
// Depends on pac_pkg and pac_div_chain.
//
// One packet descriptor is accepted per cycle unless the pipeline is stalled. Its
// result passes one decode stage, a 10-cell divider row for the payload block
// count, two stages for symbol count and dividend, a 42-cell divider row for the
// airtime by bandwidth, and the output register. Each stage holds a beat and
// takes a new one whenever its successor moves, so stalls fill bubbles first.
// Configuration is read live; write it only while no packet is in flight.
`default_nettype none
module packet_airtime_calculator_top (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            in_tvalid,
  output logic                                 in_tready,
  // payload_len[7:0], spreading_factor[11:8], zero pad
  input  wire logic [pac_pkg::IN_DATA_W-1:0]   in_tdata,
  output logic                                 out_tvalid,
  input  wire logic                            out_tready,
  // payload_syms[9:0], total_quarter_syms[28:10], airtime_us[67:29],
  // low_rate_used[68], zero pad
  output logic [pac_pkg::OUT_DATA_W-1:0]       out_tdata,
  input  wire logic                            cfg_wr_en,
  input  wire logic [pac_pkg::CFG_ADDR_W-1:0]  cfg_addr,
  input  wire logic [pac_pkg::CFG_DATA_W-1:0]  cfg_wdata
);

  // configuration registers
  logic [pac_pkg::BW_W-1:0]  bw_r;
  logic [pac_pkg::CR_W-1:0]  cr_r;
  logic                      crc_r;
  logic                      imp_r;
  logic                      lro_r;
  logic [pac_pkg::PRE_W-1:0] pre_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bw_r  <= pac_pkg::BW_LRO_KHZ;
      cr_r  <= 3'd1;
      crc_r <= 1'b1;
      imp_r <= 1'b0;
      lro_r <= 1'b0;
      pre_r <= 16'd8;
    end else if (cfg_wr_en) begin
      case (pac_pkg::cfg_reg_t'(cfg_addr))
        pac_pkg::REG_BANDWIDTH: bw_r  <= cfg_wdata[pac_pkg::BW_W-1:0];
        pac_pkg::REG_CODING:    cr_r  <= cfg_wdata[pac_pkg::CR_W-1:0];
        pac_pkg::REG_CRC:       crc_r <= cfg_wdata[0];
        pac_pkg::REG_IMPLICIT:  imp_r <= cfg_wdata[0];
        pac_pkg::REG_LRO:       lro_r <= cfg_wdata[0];
        pac_pkg::REG_PREAMBLE:  pre_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // decode stage
  logic [pac_pkg::LEN_W-1:0] in_len;
  logic [pac_pkg::SF_W-1:0]  in_sf, two_de, term_nxt;
  logic                      de_nxt, pos_nxt;
  logic signed [12:0]        num, num_m1;
  logic [pac_pkg::D1_QW-1:0] a_nxt;

  always_comb begin
    in_len   = in_tdata[7:0];
    in_sf    = in_tdata[11:8];
    de_nxt   = lro_r || (bw_r == pac_pkg::BW_LRO_KHZ && in_sf >= pac_pkg::SF_LRO_MIN);
    two_de   = {2'b00, de_nxt, 1'b0};
    term_nxt = (in_sf > two_de) ? 4'(in_sf - two_de) : 4'd1;
    num      = $signed({2'b00, in_len, 3'b000}) + 13'sd28
             + (crc_r ? 13'sd16 : 13'sd0)
             - $signed({7'b0, in_sf, 2'b00})
             - (imp_r ? 13'sd20 : 13'sd0);
    pos_nxt  = num > 13'sd0;
    num_m1   = num - 13'sd1;
    a_nxt    = pos_nxt ? num_m1[11:2] : '0;
  end

  logic                      s0_v_r, s0_ready, c1_in_ready;
  logic [pac_pkg::D1_QW-1:0] s0_a_r;
  logic [pac_pkg::SF_W-1:0]  s0_t_r;
  logic [pac_pkg::D1_SW-1:0] s0_side_r;

  assign s0_ready  = !s0_v_r || c1_in_ready;
  assign in_tready = s0_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s0_v_r <= 1'b0;
    end else if (s0_ready) begin
      s0_v_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s0_ready && in_tvalid) begin
      s0_a_r    <= a_nxt;
      s0_t_r    <= term_nxt;
      s0_side_r <= {pos_nxt, in_sf, de_nxt};
    end
  end

  // payload block division
  logic                      c1_v, s1_ready;
  logic [pac_pkg::D1_QW-1:0] c1_q;
  logic [pac_pkg::D1_SW-1:0] c1_side;

  pac_div_chain #(.RW(pac_pkg::D1_RW), .QW(pac_pkg::D1_QW), .SW(pac_pkg::D1_SW)) u_div1 (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (s0_v_r),
    .in_ready   (c1_in_ready),
    .in_dividend(s0_a_r),
    .in_div     (s0_t_r),
    .in_side    (s0_side_r),
    .out_valid  (c1_v),
    .out_ready  (s1_ready),
    .out_quot   (c1_q),
    .out_side   (c1_side)
  );

  // symbol count stage
  logic [10:0]                 blocks;
  logic [3:0]                  crp4;
  logic [14:0]                 extra;
  logic [15:0]                 sum16;
  logic [pac_pkg::SYMS_W-1:0]  syms_nxt;

  always_comb begin
    blocks   = 11'(c1_q) + 11'd1;
    crp4     = {1'b0, cr_r} + 4'd4;
    extra    = 15'(blocks) * 15'(crp4);
    sum16    = 16'(extra) + 16'(pac_pkg::SYMS_FIXED);
    if (!c1_side[5]) begin
      syms_nxt = pac_pkg::SYMS_FIXED;
    end else if (sum16 > 16'(pac_pkg::SYMS_MAX)) begin
      syms_nxt = pac_pkg::SYMS_MAX;
    end else begin
      syms_nxt = sum16[9:0];
    end
  end

  logic                       s1_v_r, s2_ready;
  logic [pac_pkg::SYMS_W-1:0] s1_syms_r;
  logic [pac_pkg::SF_W-1:0]   s1_sf_r;
  logic                       s1_de_r;

  assign s1_ready = !s1_v_r || s2_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else if (s1_ready) begin
      s1_v_r <= c1_v;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_ready && c1_v) begin
      s1_syms_r <= syms_nxt;
      s1_sf_r   <= c1_side[4:1];
      s1_de_r   <= c1_side[0];
    end
  end

  // dividend stage
  logic [pac_pkg::QUARTER_W-1:0] quarter;
  logic [26:0]                   prod;
  logic [pac_pkg::D2_QW-1:0]     dvd_nxt;
  logic [pac_pkg::BW_W-1:0]      bw_eff;

  always_comb begin
    quarter = 19'({pre_r, 2'b00}) + 19'd17 + 19'({s1_syms_r, 2'b00});
    prod    = 27'(quarter) * 27'd250;
    dvd_nxt = 42'(prod) << s1_sf_r;
    bw_eff  = (bw_r == '0) ? 9'd1 : bw_r;
  end

  logic                      s2_v_r, c2_in_ready;
  logic [pac_pkg::D2_QW-1:0] s2_dvd_r;
  logic [pac_pkg::BW_W-1:0]  s2_bw_r;
  logic [pac_pkg::D2_SW-1:0] s2_side_r;

  assign s2_ready = !s2_v_r || c2_in_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_v_r <= 1'b0;
    end else if (s2_ready) begin
      s2_v_r <= s1_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (s2_ready && s1_v_r) begin
      s2_dvd_r  <= dvd_nxt;
      s2_bw_r   <= bw_eff;
      s2_side_r <= {s1_de_r, quarter, s1_syms_r};
    end
  end

  // airtime division
  logic                      c2_v, o_ready;
  logic [pac_pkg::D2_QW-1:0] c2_q;
  logic [pac_pkg::D2_SW-1:0] c2_side;

  pac_div_chain #(.RW(pac_pkg::D2_RW), .QW(pac_pkg::D2_QW), .SW(pac_pkg::D2_SW)) u_div2 (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (s2_v_r),
    .in_ready   (c2_in_ready),
    .in_dividend(s2_dvd_r),
    .in_div     (s2_bw_r),
    .in_side    (s2_side_r),
    .out_valid  (c2_v),
    .out_ready  (o_ready),
    .out_quot   (c2_q),
    .out_side   (c2_side)
  );

  // output register
  logic [pac_pkg::AIR_W-1:0]      air;
  logic                           out_v_r;
  logic [pac_pkg::OUT_DATA_W-1:0] out_data_r;

  assign air     = (|c2_q[41:39]) ? '1 : c2_q[38:0];
  assign o_ready = !out_v_r || out_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (o_ready) begin
      out_v_r <= c2_v;
    end
  end

  always_ff @(posedge clk) begin
    if (o_ready && c2_v) begin
      out_data_r <= {3'b000, c2_side[29], air, c2_side[28:0]};
    end
  end

  assign out_tvalid = out_v_r;
  assign out_tdata  = out_data_r;

endmodule
`default_nettype wire

// File: sv/pac_div_cell.sv
// One restoring-division cell: produces one quotient bit per beat.
// Depends on nothing; used by pac_div_chain.
`default_nettype none
module pac_div_cell #(
  parameter int RW = 4,
  parameter int QW = 10,
  parameter int SW = 1
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          in_valid,
  output logic               in_ready,
  input  wire logic [RW-1:0] in_rem,
  input  wire logic [QW-1:0] in_dq,
  input  wire logic [RW-1:0] in_div,
  input  wire logic [SW-1:0] in_side,
  output logic               out_valid,
  input  wire logic          out_ready,
  output logic [RW-1:0]      out_rem,
  output logic [QW-1:0]      out_dq,
  output logic [RW-1:0]      out_div,
  output logic [SW-1:0]      out_side
);

  logic          v_r;
  logic [RW-1:0] rem_r, rem_nxt;
  logic [QW-1:0] dq_r, dq_nxt;
  logic [RW-1:0] div_r;
  logic [SW-1:0] side_r;
  logic [RW:0]   rem_ext;
  logic          ge;

  always_comb begin
    rem_ext = {in_rem, in_dq[QW-1]};
    ge      = rem_ext >= {1'b0, in_div};
    rem_nxt = ge ? RW'(rem_ext - {1'b0, in_div}) : RW'(rem_ext);
    dq_nxt  = {in_dq[QW-2:0], ge};
  end

  assign in_ready = !v_r || out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= 1'b0;
    end else if (in_ready) begin
      v_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      rem_r  <= rem_nxt;
      dq_r   <= dq_nxt;
      div_r  <= in_div;
      side_r <= in_side;
    end
  end

  assign out_valid = v_r;
  assign out_rem   = rem_r;
  assign out_dq    = dq_r;
  assign out_div   = div_r;
  assign out_side  = side_r;

endmodule
`default_nettype wire

// File: sv/pac_div_chain.sv
// Row of restoring-division cells, one quotient bit per cell.
// Depends on pac_div_cell.
`default_nettype none
module pac_div_chain #(
  parameter int RW = 4,
  parameter int QW = 10,
  parameter int SW = 1
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          in_valid,
  output logic               in_ready,
  input  wire logic [QW-1:0] in_dividend,
  input  wire logic [RW-1:0] in_div,
  input  wire logic [SW-1:0] in_side,
  output logic               out_valid,
  input  wire logic          out_ready,
  output logic [QW-1:0]      out_quot,
  output logic [SW-1:0]      out_side
);

  logic          v   [0:QW];
  logic          rdy [0:QW];
  logic [RW-1:0] rem [0:QW];
  logic [QW-1:0] dq  [0:QW];
  logic [RW-1:0] dv  [0:QW];
  logic [SW-1:0] sd  [0:QW];

  assign v[0]     = in_valid;
  assign in_ready = rdy[0];
  assign rem[0]   = '0;
  assign dq[0]    = in_dividend;
  assign dv[0]    = in_div;
  assign sd[0]    = in_side;

  for (genvar i = 0; i < QW; i++) begin : g_cell
    pac_div_cell #(.RW(RW), .QW(QW), .SW(SW)) u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .in_valid (v[i]),
      .in_ready (rdy[i]),
      .in_rem   (rem[i]),
      .in_dq    (dq[i]),
      .in_div   (dv[i]),
      .in_side  (sd[i]),
      .out_valid(v[i+1]),
      .out_ready(rdy[i+1]),
      .out_rem  (rem[i+1]),
      .out_dq   (dq[i+1]),
      .out_div  (dv[i+1]),
      .out_side (sd[i+1])
    );
  end

  assign rdy[QW]   = out_ready;
  assign out_valid = v[QW];
  assign out_quot  = dq[QW];
  assign out_side  = sd[QW];

endmodule
`default_nettype wire
